>>> src/dualpi2_pkg.sv
// shared types, constants and register map of the dual-queue coupled pi2 aqm
package dualpi2_pkg;

    // parameter defaults
    localparam int SOJOURN_WIDTH_DEF = 24;
    localparam int RANDOM_WIDTH_DEF  = 16;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 34;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // error, derivative and pi accumulator widths
    localparam int ERR_W = 33;
    localparam int ACC_W = 53;

    // probability 1.0 in q32
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // register map, index = paddr[4:2]
    localparam int          ADDR_W           = 5;
    localparam logic [2:0]  REG_L4S_TARGET   = 3'd0;
    localparam logic [2:0]  REG_CLS_TARGET   = 3'd1;
    localparam logic [2:0]  REG_COUPLING     = 3'd2;
    localparam logic [2:0]  REG_PACKET_TIME  = 3'd3;
    localparam logic [2:0]  REG_ALPHA        = 3'd4;
    localparam logic [2:0]  REG_BETA         = 3'd5;

    // register reset values
    localparam logic [23:0] L4S_TARGET_RST  = 24'd1000;
    localparam logic [23:0] CLS_TARGET_RST  = 24'd15000;
    localparam logic [11:0] COUPLING_RST    = 12'd512;
    localparam logic [23:0] PACKET_TIME_RST = 24'd3072;
    localparam logic [15:0] ALPHA_RST       = 16'd1342;
    localparam logic [15:0] BETA_RST        = 16'd13422;

    // ecn codepoints that select the l4s lane
    localparam logic [1:0] ECN_SCALABLE = 2'd1;
    localparam logic [1:0] ECN_CE       = 2'd3;

    // verdict codes
    localparam logic [2:0] V_TICK     = 3'd0;
    localparam logic [2:0] V_L4S_PASS = 3'd1;
    localparam logic [2:0] V_L4S_MARK = 3'd2;
    localparam logic [2:0] V_L4S_CE   = 3'd3;
    localparam logic [2:0] V_CLS_PASS = 3'd4;
    localparam logic [2:0] V_CLS_DROP = 3'd5;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SOJ,
        S_MEAS,
        S_ERR,
        S_DER,
        S_UPD,
        S_L4S,
        S_KMUL,
        S_VMUL,
        S_CLS
    } state_t;

endpackage

>>> src/dualpi2_mul.sv
// shared signed multiplier with registered product
module dualpi2_mul (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic signed [dualpi2_pkg::MUL_A_W-1:0] a,
    input  logic signed [dualpi2_pkg::MUL_B_W-1:0] b,
    output logic signed [dualpi2_pkg::PROD_W-1:0]  prod
);

    logic signed [dualpi2_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= dualpi2_pkg::PROD_W'(a) * dualpi2_pkg::PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

>>> src/dualq_coupled_pi2_aqm_core.sv
// top level of the dual-queue coupled pi2 aqm decision engine
// each word runs through the sequencer states in order: tick soj, meas, err, der, upd; l4s packet
//   soj, meas, l4s; classic packet soj, meas, kmul, vmul, cls; a new word is taken only when idle,
//   and the single shared multiplier that the sequencer steps through gives up to 3 products
// in_stall is high while the sequencer is busy; a finished word may wait in the output register
// reset (rst_n, async, active low) clears the pi state and loads the register defaults
module dualq_coupled_pi2_aqm_core #(
    parameter int SOJOURN_WIDTH = dualpi2_pkg::SOJOURN_WIDTH_DEF,
    parameter int RANDOM_WIDTH  = dualpi2_pkg::RANDOM_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dualpi2_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [1:0]                      ecn,
    input  logic                            head_valid,
    input  logic [23:0]                     head_sojourn_us,
    input  logic [15:0]                     queue_packets,
    input  logic [RANDOM_WIDTH-1:0]         random_q16,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      verdict,
    output logic [16:0]                     prob_used_q16,
    output logic [16:0]                     base_prob_q16
);

    localparam int          ERR_W   = dualpi2_pkg::ERR_W;
    localparam int          ACC_W   = dualpi2_pkg::ACC_W;
    localparam int          RSHIFT  = 32 - RANDOM_WIDTH;
    // largest sojourn the measure can carry
    localparam logic [32:0] SOJ_MAX = (33'd1 << SOJOURN_WIDTH) - 33'd1;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [23:0] l4s_target_reg;
    logic [23:0] cls_target_reg;
    logic [11:0] coupling_reg;
    logic [23:0] ptime_reg;
    logic [15:0] alpha_reg;
    logic [15:0] beta_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l4s_target_reg <= dualpi2_pkg::L4S_TARGET_RST;
            cls_target_reg <= dualpi2_pkg::CLS_TARGET_RST;
            coupling_reg   <= dualpi2_pkg::COUPLING_RST;
            ptime_reg      <= dualpi2_pkg::PACKET_TIME_RST;
            alpha_reg      <= dualpi2_pkg::ALPHA_RST;
            beta_reg       <= dualpi2_pkg::BETA_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                dualpi2_pkg::REG_L4S_TARGET:  l4s_target_reg <= pwdata[23:0];
                dualpi2_pkg::REG_CLS_TARGET:  cls_target_reg <= pwdata[23:0];
                dualpi2_pkg::REG_COUPLING:    coupling_reg   <= pwdata[11:0];
                dualpi2_pkg::REG_PACKET_TIME: ptime_reg      <= pwdata[23:0];
                dualpi2_pkg::REG_ALPHA:       alpha_reg      <= pwdata[15:0];
                dualpi2_pkg::REG_BETA:        beta_reg       <= pwdata[15:0];
                default:                      ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[4:2])
            dualpi2_pkg::REG_L4S_TARGET:  prdata = 32'(l4s_target_reg);
            dualpi2_pkg::REG_CLS_TARGET:  prdata = 32'(cls_target_reg);
            dualpi2_pkg::REG_COUPLING:    prdata = 32'(coupling_reg);
            dualpi2_pkg::REG_PACKET_TIME: prdata = 32'(ptime_reg);
            dualpi2_pkg::REG_ALPHA:       prdata = 32'(alpha_reg);
            dualpi2_pkg::REG_BETA:        prdata = 32'(beta_reg);
            default:                      prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer state and captured input word
    // ---------------------------------------------------------------
    dualpi2_pkg::state_t state_reg, state_next;

    logic                     mode_reg;
    logic [1:0]               ecn_reg;
    logic                     hv_reg;
    logic [23:0]              head_reg;
    logic [15:0]              qlen_reg;
    logic [RANDOM_WIDTH-1:0]  rnd_reg;

    logic in_accept;
    assign in_stall  = (state_reg != dualpi2_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // output register slot is free when empty or being drained this cycle
    logic out_valid_reg;
    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    // ---------------------------------------------------------------
    // shared multiplier
    // ---------------------------------------------------------------
    logic                                    mul_load;
    logic signed [dualpi2_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [dualpi2_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [dualpi2_pkg::PROD_W-1:0]   prod;

    dualpi2_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // pi state and working registers
    logic [32:0]              base_reg;
    logic [SOJOURN_WIDTH-1:0] prev_reg;
    logic                     prev_valid_reg;
    logic [SOJOURN_WIDTH-1:0] soj_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  der_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     vsat_reg;

    // operand select: one product per state
    always_comb
    begin
        mul_load = 1'b1;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            dualpi2_pkg::S_SOJ:
            begin
                // fallback proxy: queue length times per-packet time
                mul_a = dualpi2_pkg::MUL_A_W'(qlen_reg);
                mul_b = dualpi2_pkg::MUL_B_W'(ptime_reg);
            end
            dualpi2_pkg::S_ERR:
            begin
                mul_a = dualpi2_pkg::MUL_A_W'(alpha_reg);
                mul_b = dualpi2_pkg::MUL_B_W'(err_reg);
            end
            dualpi2_pkg::S_DER:
            begin
                mul_a = dualpi2_pkg::MUL_A_W'(beta_reg);
                mul_b = dualpi2_pkg::MUL_B_W'(der_reg);
            end
            dualpi2_pkg::S_KMUL:
            begin
                mul_a = dualpi2_pkg::MUL_A_W'(coupling_reg);
                mul_b = dualpi2_pkg::MUL_B_W'(base_reg);
            end
            dualpi2_pkg::S_VMUL:
            begin
                // square the low 32 bits of k*p >> 8
                mul_a = dualpi2_pkg::MUL_A_W'(prod[39:8]);
                mul_b = dualpi2_pkg::MUL_B_W'(prod[39:8]);
            end
            default:
            begin
                mul_load = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // datapath pieces per state
    // ---------------------------------------------------------------
    // sojourn measure with saturation, and pi error terms
    logic [31:0]              soj_raw;
    logic [SOJOURN_WIDTH-1:0] soj_sat;
    logic signed [ERR_W-1:0]  err_next;
    logic signed [ERR_W-1:0]  der_next;

    always_comb
    begin
        soj_raw = hv_reg ? 32'(head_reg) : prod[39:8];
        if ({1'b0, soj_raw} > SOJ_MAX)
        begin
            soj_sat = '1;
        end
        else
        begin
            soj_sat = soj_raw[SOJOURN_WIDTH-1:0];
        end
        err_next = $signed(ERR_W'(soj_sat) - ERR_W'(cls_target_reg));
        // derivative is zero on the first tick
        if (prev_valid_reg)
        begin
            der_next = $signed(ERR_W'(soj_sat) - ERR_W'(prev_reg));
        end
        else
        begin
            der_next = '0;
        end
    end

    // pi update with clamp to [0, 1]
    logic signed [ACC_W-1:0] np_full;
    logic [32:0]             np_clamped;

    always_comb
    begin
        np_full = acc_reg + $signed(prod[ACC_W-1:0]);
        if (np_full < 0)
        begin
            np_clamped = '0;
        end
        else if (np_full > $signed(ACC_W'(dualpi2_pkg::ONE_Q32)))
        begin
            np_clamped = dualpi2_pkg::ONE_Q32;
        end
        else
        begin
            np_clamped = np_full[32:0];
        end
    end

    // l4s lane probability: 1 at or above target, else min(2p, 1)
    logic [33:0] base_dbl;
    logic [32:0] p_l4s;

    always_comb
    begin
        base_dbl = {base_reg, 1'b0};
        if (32'(soj_reg) >= 32'(l4s_target_reg))
        begin
            p_l4s = dualpi2_pkg::ONE_Q32;
        end
        else if (base_dbl > 34'(dualpi2_pkg::ONE_Q32))
        begin
            p_l4s = dualpi2_pkg::ONE_Q32;
        end
        else
        begin
            p_l4s = base_dbl[32:0];
        end
    end

    // classic lane probability: (k*p)^2 with k*p saturated at 1
    logic [32:0] p_cls;
    assign p_cls = vsat_reg ? dualpi2_pkg::ONE_Q32 : {1'b0, prod[63:32]};

    // random draw scaled to q32; fires strictly below a nonzero probability
    logic [32:0] rnd_q32;
    logic        fire_l4s;
    logic        fire_cls;

    assign rnd_q32  = {1'b0, 32'(rnd_reg) << RSHIFT};
    assign fire_l4s = (p_l4s != 33'd0) && (rnd_q32 < p_l4s);
    assign fire_cls = (p_cls != 33'd0) && (rnd_q32 < p_cls);

    // ---------------------------------------------------------------
    // next state and output word load
    // ---------------------------------------------------------------
    logic        out_load;
    logic [2:0]  verdict_next;
    logic [32:0] used_next;
    logic [32:0] base_out_next;

    always_comb
    begin
        state_next    = state_reg;
        out_load      = 1'b0;
        verdict_next  = dualpi2_pkg::V_TICK;
        used_next     = '0;
        base_out_next = base_reg;
        unique case (state_reg)
            dualpi2_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = dualpi2_pkg::S_SOJ;
                end
            end
            dualpi2_pkg::S_SOJ:
            begin
                state_next = dualpi2_pkg::S_MEAS;
            end
            dualpi2_pkg::S_MEAS:
            begin
                if (!mode_reg)
                begin
                    state_next = dualpi2_pkg::S_ERR;
                end
                else if (ecn_reg == dualpi2_pkg::ECN_SCALABLE || ecn_reg == dualpi2_pkg::ECN_CE)
                begin
                    state_next = dualpi2_pkg::S_L4S;
                end
                else
                begin
                    state_next = dualpi2_pkg::S_KMUL;
                end
            end
            dualpi2_pkg::S_ERR:
            begin
                state_next = dualpi2_pkg::S_DER;
            end
            dualpi2_pkg::S_DER:
            begin
                state_next = dualpi2_pkg::S_UPD;
            end
            dualpi2_pkg::S_UPD:
            begin
                verdict_next  = dualpi2_pkg::V_TICK;
                base_out_next = np_clamped;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = dualpi2_pkg::S_IDLE;
                end
            end
            dualpi2_pkg::S_L4S:
            begin
                used_next = p_l4s;
                if (!fire_l4s)
                begin
                    verdict_next = dualpi2_pkg::V_L4S_PASS;
                end
                else if (ecn_reg == dualpi2_pkg::ECN_CE)
                begin
                    verdict_next = dualpi2_pkg::V_L4S_CE;
                end
                else
                begin
                    verdict_next = dualpi2_pkg::V_L4S_MARK;
                end
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = dualpi2_pkg::S_IDLE;
                end
            end
            dualpi2_pkg::S_KMUL:
            begin
                state_next = dualpi2_pkg::S_VMUL;
            end
            dualpi2_pkg::S_VMUL:
            begin
                state_next = dualpi2_pkg::S_CLS;
            end
            dualpi2_pkg::S_CLS:
            begin
                used_next    = p_cls;
                verdict_next = fire_cls ? dualpi2_pkg::V_CLS_DROP : dualpi2_pkg::V_CLS_PASS;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = dualpi2_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dualpi2_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dualpi2_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // captured input word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode;
            ecn_reg  <= ecn;
            hv_reg   <= head_valid;
            head_reg <= head_sojourn_us;
            qlen_reg <= queue_packets;
            rnd_reg  <= random_q16;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == dualpi2_pkg::S_MEAS)
        begin
            soj_reg <= soj_sat;
            err_reg <= err_next;
            der_reg <= der_next;
        end
        if (state_reg == dualpi2_pkg::S_DER)
        begin
            // base plus alpha*err, beta*der follows
            acc_reg <= ACC_W'(base_reg) + $signed(prod[ACC_W-1:0]);
        end
        if (state_reg == dualpi2_pkg::S_VMUL)
        begin
            vsat_reg <= |prod[44:40];
        end
    end

    // pi state: only a tick changes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (state_reg == dualpi2_pkg::S_UPD && out_free)
        begin
            base_reg       <= np_clamped;
            prev_reg       <= soj_reg;
            prev_valid_reg <= 1'b1;
        end
    end

    // output register
    logic [2:0]  verdict_reg;
    logic [16:0] used_reg;
    logic [16:0] base_q16_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            verdict_reg  <= verdict_next;
            used_reg     <= used_next[32:16];
            base_q16_reg <= base_out_next[32:16];
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign prob_used_q16 = used_reg;
    assign base_prob_q16 = base_q16_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // base probability stays within [0, 1]
    a_base_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg <= dualpi2_pkg::ONE_Q32)
        else $error("base probability above 1.0");

    // packet words never move the pi state
    a_base_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dualpi2_pkg::S_UPD) |=> $stable(base_reg))
        else $error("base probability changed outside a tick update");

    // a tick word on the output means the previous sojourn is recorded
    a_tick_sets_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict == dualpi2_pkg::V_TICK) |-> prev_valid_reg)
        else $error("tick word delivered without previous sojourn");

    // a word is only produced by a busy sequencer
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word appeared while sequencer idle");

endmodule

>>> tb/sv/dualq_coupled_pi2_aqm_core_tb.sv
// self-checking testbench of the dual-queue coupled pi2 aqm core, directed and random words
module dualq_coupled_pi2_aqm_core_tb;

    // word field codes the package does not name
    localparam logic       MODE_TICK   = 1'b0;
    localparam logic       MODE_PACKET = 1'b1;
    localparam logic [1:0] ECN_NOT_ECT = 2'd0;
    localparam logic [1:0] ECN_ECT0    = 2'd2;

    localparam logic [23:0] SOJ_SAT    = 24'hFF_FFFF;
    localparam longint      SOJ_TOP    = 64'hFF_FFFF;
    localparam int          HOLD_SPAN  = 400;
    localparam int          DRAIN_WAIT = 20;

    // one input word and one result word
    typedef struct packed {
        logic        mode;
        logic [1:0]  ecn;
        logic        head_valid;
        logic [23:0] head_sojourn_us;
        logic [15:0] queue_packets;
        logic [15:0] random_q16;
    } aqm_word_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [16:0] prob_used_q16;
        logic [16:0] base_prob_q16;
    } aqm_outcome_t;

    // receiver stall patterns
    typedef enum int {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_style_t;

    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [dualpi2_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                    pwdata  = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           in_valid        = 1'b0;
    logic                           in_stall;
    logic                           mode            = 1'b0;
    logic [1:0]                     ecn             = '0;
    logic                           head_valid      = 1'b0;
    logic [23:0]                    head_sojourn_us = '0;
    logic [15:0]                    queue_packets   = '0;
    logic [15:0]                    random_q16      = '0;
    logic                           out_valid;
    logic                           out_stall       = 1'b0;
    logic [2:0]                     verdict;
    logic [16:0]                    prob_used_q16;
    logic [16:0]                    base_prob_q16;

    dualq_coupled_pi2_aqm_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .ecn             (ecn),
        .head_valid      (head_valid),
        .head_sojourn_us (head_sojourn_us),
        .queue_packets   (queue_packets),
        .random_q16      (random_q16),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .verdict         (verdict),
        .prob_used_q16   (prob_used_q16),
        .base_prob_q16   (base_prob_q16)
    );

    // register copies, kept in step with every bus write
    logic [23:0] cfg_l4s_target  = dualpi2_pkg::L4S_TARGET_RST;
    logic [23:0] cfg_cls_target  = dualpi2_pkg::CLS_TARGET_RST;
    logic [11:0] cfg_coupling    = dualpi2_pkg::COUPLING_RST;
    logic [23:0] cfg_packet_time = dualpi2_pkg::PACKET_TIME_RST;
    logic [15:0] cfg_alpha       = dualpi2_pkg::ALPHA_RST;
    logic [15:0] cfg_beta        = dualpi2_pkg::BETA_RST;

    // pi controller state as the predictor sees it
    logic [32:0] pi_base     = '0;
    logic [23:0] pi_prev_soj = '0;
    logic        pi_prev_ok  = 1'b0;

    aqm_word_t    pending_words[$];
    aqm_outcome_t expected_verdicts[$];

    // sender and receiver control
    aqm_word_t drive_word   = '0;
    logic      word_taken   = 1'b0;
    logic      sender_gaps  = 1'b1;
    int        burst_left   = 0;
    int        gap_left     = 0;
    rx_style_t rx_style     = RX_LIGHT;
    logic      hold_request = 1'b0;
    int        hold_left    = 0;
    int        rx_phase     = 0;

    // bookkeeping
    int errors           = 0;
    int words_accepted   = 0;
    int results_checked  = 0;
    int settings_applied = 0;
    int verdict_seen[6];

    // sojourn measure: head timestamp, else queue length times packet time, saturated
    function automatic logic [23:0] measured_sojourn(aqm_word_t w);
        logic [63:0] s;
        if (w.head_valid)
            s = {40'd0, w.head_sojourn_us};
        else
            s = ({48'd0, w.queue_packets} * {40'd0, cfg_packet_time}) >> 8;
        if (s > {40'd0, SOJ_SAT})
            s = {40'd0, SOJ_SAT};
        return s[23:0];
    endfunction

    // draw scaled to q32 fires strictly below p, never at p = 0
    function automatic logic draw_fires(logic [15:0] rnd, logic [32:0] p);
        logic [32:0] r;
        r = {1'b0, rnd, 16'd0};
        return (p != '0) && (r < p);
    endfunction

    // decision for one accepted word; a tick also advances the pi state
    function automatic aqm_outcome_t aqm_decide(aqm_word_t w);
        aqm_outcome_t res;
        logic [23:0]  s;
        longint       err;
        longint       der;
        longint       np;
        logic [63:0]  v;
        logic [63:0]  pc;
        logic [32:0]  used;
        s    = measured_sojourn(w);
        used = '0;
        if (w.mode == MODE_TICK)
        begin
            err = longint'({40'd0, s}) - longint'({40'd0, cfg_cls_target});
            der = pi_prev_ok ? longint'({40'd0, s}) - longint'({40'd0, pi_prev_soj}) : 0;
            np  = longint'({31'd0, pi_base})
                  + longint'({48'd0, cfg_alpha}) * err
                  + longint'({48'd0, cfg_beta}) * der;
            if (np < 0)
                np = 0;
            if (np > longint'({31'd0, dualpi2_pkg::ONE_Q32}))
                np = longint'({31'd0, dualpi2_pkg::ONE_Q32});
            pi_base     = np[32:0];
            pi_prev_soj = s;
            pi_prev_ok  = 1'b1;
            res.verdict = dualpi2_pkg::V_TICK;
        end
        else if (w.ecn == dualpi2_pkg::ECN_SCALABLE || w.ecn == dualpi2_pkg::ECN_CE)
        begin
            if (s >= cfg_l4s_target)
                used = dualpi2_pkg::ONE_Q32;
            else
            begin
                v    = {31'd0, pi_base} << 1;
                used = (v > {31'd0, dualpi2_pkg::ONE_Q32}) ? dualpi2_pkg::ONE_Q32 : v[32:0];
            end
            if (draw_fires(w.random_q16, used))
                res.verdict = (w.ecn == dualpi2_pkg::ECN_CE) ? dualpi2_pkg::V_L4S_CE
                                                             : dualpi2_pkg::V_L4S_MARK;
            else
                res.verdict = dualpi2_pkg::V_L4S_PASS;
        end
        else
        begin
            v = ({52'd0, cfg_coupling} * {31'd0, pi_base}) >> 8;
            if (v >= {31'd0, dualpi2_pkg::ONE_Q32})
                pc = {31'd0, dualpi2_pkg::ONE_Q32};
            else
                pc = (v * v) >> 32;
            used        = pc[32:0];
            res.verdict = draw_fires(w.random_q16, used) ? dualpi2_pkg::V_CLS_DROP
                                                         : dualpi2_pkg::V_CLS_PASS;
        end
        res.prob_used_q16 = used[32:16];
        res.base_prob_q16 = pi_base[32:16];
        return res;
    endfunction

    function automatic aqm_word_t make_word(logic m, logic [1:0] e, logic hv,
                                            logic [23:0] soj, logic [15:0] qp,
                                            logic [15:0] rnd);
        aqm_word_t w;
        w.mode            = m;
        w.ecn             = e;
        w.head_valid      = hv;
        w.head_sojourn_us = soj;
        w.queue_packets   = qp;
        w.random_q16      = rnd;
        return w;
    endfunction

    // random word: sojourn mostly around the classic target for ticks, the l4s target for packets
    function automatic aqm_word_t random_word(int tick_pct, int spread);
        aqm_word_t   w;
        int unsigned pick;
        longint      center;
        longint      soj;
        w.mode       = ($urandom_range(0, 99) < tick_pct) ? MODE_TICK : MODE_PACKET;
        w.ecn        = 2'($urandom_range(0, 3));
        w.head_valid = ($urandom_range(0, 7) != 0);
        center       = (w.mode == MODE_TICK) ? longint'({40'd0, cfg_cls_target})
                                             : longint'({40'd0, cfg_l4s_target});
        pick = $urandom_range(0, 19);
        if (pick == 0)
            w.head_sojourn_us = '0;
        else if (pick == 1)
            w.head_sojourn_us = SOJ_SAT;
        else if (pick < 4)
            w.head_sojourn_us = 24'($urandom());
        else
        begin
            soj = center + longint'($urandom_range(0, 2 * spread)) - spread;
            if (soj < 0)
                soj = 0;
            if (soj > SOJ_TOP)
                soj = SOJ_TOP;
            w.head_sojourn_us = soj[23:0];
        end
        w.queue_packets = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 4000));
        w.random_q16    = 16'($urandom());
        return w;
    endfunction

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_verdicts.size());
        $display("dualq_coupled_pi2_aqm_core regression: fail");
        $finish;
    end

    // input side: take note of every accepted word and predict its result
    always @(posedge clk)
    begin : acceptor
        if (rst_n && in_valid && !in_stall)
        begin
            expected_verdicts.push_back(aqm_decide(drive_word));
            word_taken = 1'b1;
            words_accepted++;
        end
    end

    // sender: bursts of random length, random gaps, payload held while stalled
    always @(negedge clk)
    begin : sender
        if (rst_n && (word_taken || !in_valid))
        begin
            word_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                drive_word = pending_words.pop_front();
                in_valid        <= 1'b1;
                mode            <= drive_word.mode;
                ecn             <= drive_word.ecn;
                head_valid      <= drive_word.head_valid;
                head_sojourn_us <= drive_word.head_sojourn_us;
                queue_packets   <= drive_word.queue_packets;
                random_q16      <= drive_word.random_q16;
                if (burst_left > 0)
                    burst_left--;
                else if (sender_gaps)
                begin
                    // end of burst, pick the next gap and burst
                    burst_left = $urandom_range(0, 15);
                    gap_left   = $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern per phase, or one long hold-off on request
    always @(negedge clk)
    begin : receiver
        if (hold_request)
        begin
            hold_left    = HOLD_SPAN;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (rx_style)
                RX_FREE:     out_stall <= 1'b0;
                RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: out_stall <= ((rx_phase % 9) < 4);
                default:     out_stall <= ($urandom_range(0, 9) < 6);
            endcase
        end
        rx_phase++;
    end

    // output side: compare each result word with the oldest prediction
    always @(posedge clk)
    begin : monitor
        aqm_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: result word with nothing expected, verdict %0d prob %0d base %0d",
                         $time, verdict, prob_used_q16, base_prob_q16);
                errors++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (verdict !== want.verdict)
                begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, want.verdict, verdict);
                    errors++;
                end
                if (prob_used_q16 !== want.prob_used_q16)
                begin
                    $display("%0t: prob_used_q16 expected %0d actual %0d",
                             $time, want.prob_used_q16, prob_used_q16);
                    errors++;
                end
                if (base_prob_q16 !== want.base_prob_q16)
                begin
                    $display("%0t: base_prob_q16 expected %0d actual %0d",
                             $time, want.base_prob_q16, base_prob_q16);
                    errors++;
                end
                results_checked++;
                if (verdict <= dualpi2_pkg::V_CLS_DROP)
                    verdict_seen[verdict]++;
            end
        end
    end

    // register write: setup cycle, access cycle, commit at the edge with pready
    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (index)
            dualpi2_pkg::REG_L4S_TARGET:  cfg_l4s_target  = value[23:0];
            dualpi2_pkg::REG_CLS_TARGET:  cfg_cls_target  = value[23:0];
            dualpi2_pkg::REG_COUPLING:    cfg_coupling    = value[11:0];
            dualpi2_pkg::REG_PACKET_TIME: cfg_packet_time = value[23:0];
            dualpi2_pkg::REG_ALPHA:       cfg_alpha       = value[15:0];
            dualpi2_pkg::REG_BETA:        cfg_beta        = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(logic [23:0] l4s_t, logic [23:0] cls_t, logic [11:0] k,
                                  logic [23:0] pkt_t, logic [15:0] a, logic [15:0] b);
        write_reg(dualpi2_pkg::REG_L4S_TARGET,  {8'd0, l4s_t});
        write_reg(dualpi2_pkg::REG_CLS_TARGET,  {8'd0, cls_t});
        write_reg(dualpi2_pkg::REG_COUPLING,    {20'd0, k});
        write_reg(dualpi2_pkg::REG_PACKET_TIME, {8'd0, pkt_t});
        write_reg(dualpi2_pkg::REG_ALPHA,       {16'd0, a});
        write_reg(dualpi2_pkg::REG_BETA,        {16'd0, b});
        settings_applied++;
    endtask

    // wait until every word is in and every result is out, then let the pipe settle
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic queue_random(int n, int tick_pct, int spread);
        repeat (n) pending_words.push_back(random_word(tick_pct, spread));
    endtask

    initial
    begin
        // reset once, released at a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed words on the reset settings
        rx_style    = RX_LIGHT;
        sender_gaps = 1'b1;
        // first tick: no derivative, ignores ecn and draw
        pending_words.push_back(make_word(MODE_TICK, dualpi2_pkg::ECN_CE, 1'b1, 24'd20000,
                                          16'd0, 16'hFFFF));
        pending_words.push_back(make_word(MODE_TICK, ECN_NOT_ECT, 1'b1, 24'd30000, 16'd7, 16'd0));
        // short fallback queue drives the probability below zero, clamped
        pending_words.push_back(make_word(MODE_TICK, dualpi2_pkg::ECN_SCALABLE, 1'b0,
                                          24'hABCDEF, 16'd10, 16'd5));
        // longest sojourn clamps at one
        pending_words.push_back(make_word(MODE_TICK, ECN_ECT0, 1'b1, SOJ_SAT, 16'hFFFF, 16'h1234));
        // probability one: l4s marks at any draw, classic saturates k*p
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd0,
                                          16'd0, 16'd0));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd0,
                                          16'd0, 16'hFFFF));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_CE, 1'b1, 24'd0,
                                          16'd0, 16'h8000));
        pending_words.push_back(make_word(MODE_PACKET, ECN_NOT_ECT, 1'b1, 24'd0, 16'd0, 16'hFFFF));
        pending_words.push_back(make_word(MODE_PACKET, ECN_ECT0, 1'b1, 24'd0, 16'd0, 16'd0));
        // full fallback queue stays under the sojourn limit; the falling sojourn drives p to zero
        pending_words.push_back(make_word(MODE_TICK, ECN_NOT_ECT, 1'b0, 24'd0, 16'hFFFF, 16'd0));
        pending_words.push_back(make_word(MODE_TICK, ECN_NOT_ECT, 1'b1, 24'd0, 16'd0, 16'd0));
        // probability zero: l4s marks only at its sojourn target, nothing else fires
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd1000,
                                          16'd0, 16'hFFFF));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd999,
                                          16'd0, 16'd0));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_CE, 1'b1, 24'd999,
                                          16'd0, 16'd0));
        pending_words.push_back(make_word(MODE_PACKET, ECN_NOT_ECT, 1'b1, 24'd0, 16'd0, 16'd0));
        // derivative alone lifts p to a middle value, then a flat tick
        pending_words.push_back(make_word(MODE_TICK, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd15000,
                                          16'd0, 16'd9));
        pending_words.push_back(make_word(MODE_TICK, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd15000,
                                          16'd0, 16'd9));
        // middle probability: both outcomes on both lanes, ce not drawn passes
        pending_words.push_back(make_word(MODE_PACKET, ECN_NOT_ECT, 1'b1, 24'd0, 16'd0, 16'd0));
        pending_words.push_back(make_word(MODE_PACKET, ECN_ECT0, 1'b1, 24'd0, 16'd0, 16'hFFFF));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd0,
                                          16'd0, 16'd0));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_SCALABLE, 1'b1, 24'd0,
                                          16'd0, 16'hFFFF));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_CE, 1'b1, 24'd0,
                                          16'd0, 16'd0));
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_CE, 1'b1, 24'd0,
                                          16'd0, 16'hFFFF));
        // l4s fallback sojourn above its target
        pending_words.push_back(make_word(MODE_PACKET, dualpi2_pkg::ECN_CE, 1'b0, 24'd0,
                                          16'd100, 16'hFFFF));
        // fallback exactly at the classic target
        pending_words.push_back(make_word(MODE_TICK, ECN_ECT0, 1'b0, 24'd0, 16'd1250, 16'd77));
        drain();

        // reset settings, random words
        queue_random(150, 40, 3000);
        drain();

        // fast loop: big gains, short targets, k = 1.0
        apply_settings(24'd500, 24'd2000, 12'd256, 24'd256, 16'hFFFF, 16'hFFFF);
        queue_random(150, 40, 2000);
        drain();

        // every register at zero: frozen p, l4s always at target, no classic drops
        rx_style = RX_PERIODIC;
        apply_settings(24'd0, 24'd0, 12'd0, 24'd0, 16'd0, 16'd0);
        queue_random(100, 30, 1000);
        drain();

        // every register at its maximum
        rx_style = RX_HEAVY;
        apply_settings(SOJ_SAT, SOJ_SAT, 12'hFFF, SOJ_SAT, 16'hFFFF, 16'hFFFF);
        queue_random(100, 40, 30000);
        drain();

        // random settings, sender never idles, receiver holds off long enough to back up the core
        rx_style    = RX_PERIODIC;
        sender_gaps = 1'b0;
        burst_left  = 0;
        apply_settings(24'($urandom_range(0, 5000)), 24'($urandom_range(500, 30000)),
                       12'($urandom_range(0, 4095)), 24'($urandom_range(0, 8192)),
                       16'($urandom()), 16'($urandom()));
        queue_random(250, 35, 5000);
        hold_request = 1'b1;
        drain();

        // another random setting, no idling on either side
        rx_style = RX_FREE;
        apply_settings(24'($urandom_range(0, 5000)), 24'($urandom_range(500, 30000)),
                       12'($urandom_range(0, 4095)), 24'($urandom_range(0, 8192)),
                       16'($urandom()), 16'($urandom()));
        queue_random(150, 35, 5000);
        drain();

        $display("summary: %0d words in, %0d results checked, %0d register settings written",
                 words_accepted, results_checked, settings_applied);
        $display("summary: ticks %0d, l4s pass/mark/ce %0d/%0d/%0d, classic accept/drop %0d/%0d",
                 verdict_seen[dualpi2_pkg::V_TICK], verdict_seen[dualpi2_pkg::V_L4S_PASS],
                 verdict_seen[dualpi2_pkg::V_L4S_MARK], verdict_seen[dualpi2_pkg::V_L4S_CE],
                 verdict_seen[dualpi2_pkg::V_CLS_PASS], verdict_seen[dualpi2_pkg::V_CLS_DROP]);
        if (errors == 0)
            $display("dualq_coupled_pi2_aqm_core regression: pass");
        else
            $display("dualq_coupled_pi2_aqm_core regression: fail");
        $finish;
    end

endmodule
